### sv/art_pkg.sv
// ----------------------------------------------------------------------------
// Allocation record table package
// Shared types, result codes and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package art_pkg;

   localparam int ART_DEPTH = 64;
   localparam int ADDR_W    = 64;
   localparam int HEAP_W    = 64;
   localparam int SIZE_W    = 32;
   localparam int CODE_W    = 3;

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   localparam logic [CODE_W-1:0] RC_UPDATED = 3'd0;
   localparam logic [CODE_W-1:0] RC_ADDED   = 3'd1;
   localparam logic [CODE_W-1:0] RC_FULL    = 3'd2;
   localparam logic [CODE_W-1:0] RC_LEAK    = 3'd3;
   localparam logic [CODE_W-1:0] RC_NOLEAK  = 3'd4;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [HEAP_W-1:0] heap;
      logic [SIZE_W-1:0] size;
      logic              freed;
   } entry_type;

   typedef struct packed {
      logic              start;
      logic              advance;
      logic              wr_hit;
      logic              wr_add;
      logic              hold_load;
      logic              load_rsp;
      logic              rsp_from_hold;
      logic              rsp_last;
      logic [CODE_W-1:0] rsp_code;
   } art_cmd_type;

   typedef struct packed {
      logic hit;
      logic chk_last;
      logic rd_live;
      logic rd_freed;
      logic count_zero;
      logic count_full;
      logic hold_valid;
      logic rsp_free;
   } art_status_type;

endpackage

### sv/art_if.sv
// ----------------------------------------------------------------------------
// Allocation record table channels
// Request and response interfaces with valid/ready flow control.
// ----------------------------------------------------------------------------
interface art_req_if;
   import art_pkg::*;

   logic              valid;
   logic              ready;
   logic              opcode;
   logic [ADDR_W-1:0] block_address;
   logic [HEAP_W-1:0] heap_handle;
   logic [SIZE_W-1:0] block_size;
   logic              is_free;

   modport source (output valid, opcode, block_address, heap_handle, block_size, is_free,
                   input ready);
   modport sink (input valid, opcode, block_address, heap_handle, block_size, is_free,
                 output ready);
endinterface

interface art_rsp_if;
   import art_pkg::*;

   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] result_code;
   logic [ADDR_W-1:0] leak_address;
   logic [SIZE_W-1:0] leak_size;
   logic [SIZE_W-1:0] leaked_total;
   logic              last;

   modport source (output valid, result_code, leak_address, leak_size, leaked_total, last,
                   input ready);
   modport sink (input valid, result_code, leak_address, leak_size, leaked_total, last,
                 output ready);
endinterface

### sv/allocation_record_table_unit.sv
// ----------------------------------------------------------------------------
// Allocation record table unit
// Records allocation and free events per address and heap, and reports the
// blocks that are still allocated with a running total of leaked bytes.
//
// A request word with opcode record looks up its address and heap pair and
// returns one response word: updated, added, or table full. A request word
// with opcode report returns one response word per unfreed entry in table
// order, the last one flagged, or a single no-leaks word.
// The entry memory is searched one entry per cycle through its single read
// port, except while a stalled receiver holds a report's scan. A new
// request is taken only after the final response word of the last one has
// been loaded into the output register.
// Reset empties the table at once and drops any response word in flight.
// When the receiver stalls, the report holds its scan until the output
// register frees up; no word is lost.
// ----------------------------------------------------------------------------
module allocation_record_table_unit
   import art_pkg::*;
#(
   parameter int DEPTH = ART_DEPTH
) (
   input logic     clock,
   input logic     reset,
   art_req_if.sink   req_chan,
   art_rsp_if.source rsp_chan
);

   art_cmd_type    cmd;
   art_status_type status;

   art_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_chan.ready),
      .status     (status),
      .cmd        (cmd)
   );

   art_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_block_address (req_chan.block_address),
      .req_heap_handle   (req_chan.heap_handle),
      .req_block_size    (req_chan.block_size),
      .req_is_free       (req_chan.is_free),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_result_code   (rsp_chan.result_code),
      .rsp_leak_address  (rsp_chan.leak_address),
      .rsp_leak_size     (rsp_chan.leak_size),
      .rsp_leaked_total  (rsp_chan.leaked_total),
      .rsp_last          (rsp_chan.last)
   );

   a_no_add_when_full: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_add && status.count_full))
      else $error("append issued while the table is full");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_add && cmd.wr_hit))
      else $error("update and append issued together");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> status.rsp_free)
      else $error("response register overwritten while still held");

   a_hold_flushed: assert property (@(posedge clock) disable iff (reset)
      (cmd.hold_load && status.hold_valid) |-> (cmd.load_rsp && cmd.rsp_from_hold))
      else $error("pending leak word replaced without being sent");

endmodule

### sv/art_datapath.sv
// ----------------------------------------------------------------------------
// Allocation record table datapath
// Entry memory, scan pointers, pending leak word and the response register.
// ----------------------------------------------------------------------------
module art_datapath
   import art_pkg::*;
#(
   parameter int DEPTH = ART_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [ADDR_W-1:0] req_block_address,
   input  logic [HEAP_W-1:0] req_heap_handle,
   input  logic [SIZE_W-1:0] req_block_size,
   input  logic              req_is_free,
   input  art_cmd_type       cmd,
   output art_status_type    status,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [CODE_W-1:0] rsp_result_code,
   output logic [ADDR_W-1:0] rsp_leak_address,
   output logic [SIZE_W-1:0] rsp_leak_size,
   output logic [SIZE_W-1:0] rsp_leaked_total,
   output logic              rsp_last
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   entry_type mem [DEPTH];

   entry_type         rd_word_ff;
   logic              rd_live_ff;
   logic [CNT_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  chk_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              rd_more;

   logic [ADDR_W-1:0] addr_ff;
   logic [HEAP_W-1:0] heap_ff;
   logic [SIZE_W-1:0] size_ff;
   logic              free_ff;

   logic              hold_valid_ff;
   logic [ADDR_W-1:0] hold_addr_ff;
   logic [SIZE_W-1:0] hold_size_ff;
   logic [SIZE_W-1:0] hold_total_ff;

   logic              rsp_valid_ff;
   logic [CODE_W-1:0] rsp_code_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [SIZE_W-1:0] rsp_size_ff;
   logic [SIZE_W-1:0] rsp_total_ff;
   logic              rsp_last_ff;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   entry_type         wr_word;

   assign rd_more = rd_ptr_ff < count_ff;

   always_comb begin
      wr_en         = cmd.wr_hit || cmd.wr_add;
      wr_idx        = cmd.wr_hit ? chk_ptr_ff[IDX_W-1:0] : count_ff[IDX_W-1:0];
      wr_word.address = addr_ff;
      wr_word.heap    = heap_ff;
      wr_word.freed   = free_ff;
      wr_word.size    = (cmd.wr_hit && free_ff) ? rd_word_ff.size : size_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_word;
      end
      if (cmd.advance && rd_more) begin
         rd_word_ff <= mem[rd_ptr_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rd_ptr_ff     <= '0;
         chk_ptr_ff    <= '0;
         rd_live_ff    <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.start) begin
            rd_ptr_ff     <= '0;
            rd_live_ff    <= 1'b0;
            hold_valid_ff <= 1'b0;
         end else if (cmd.advance) begin
            rd_live_ff <= rd_more;
            chk_ptr_ff <= rd_ptr_ff;
            if (rd_more) begin
               rd_ptr_ff <= rd_ptr_ff + CNT_W'(1);
            end
         end
         if (cmd.hold_load) begin
            hold_valid_ff <= 1'b1;
         end
         if (cmd.wr_add) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         addr_ff       <= req_block_address;
         heap_ff       <= req_heap_handle;
         size_ff       <= req_block_size;
         free_ff       <= req_is_free;
         hold_total_ff <= '0;
      end
      if (cmd.hold_load) begin
         hold_addr_ff  <= rd_word_ff.address;
         hold_size_ff  <= rd_word_ff.size;
         hold_total_ff <= hold_total_ff + rd_word_ff.size;
      end
      if (cmd.load_rsp) begin
         rsp_code_ff  <= cmd.rsp_code;
         rsp_last_ff  <= cmd.rsp_last;
         rsp_addr_ff  <= cmd.rsp_from_hold ? hold_addr_ff : '0;
         rsp_size_ff  <= cmd.rsp_from_hold ? hold_size_ff : '0;
         rsp_total_ff <= cmd.rsp_from_hold ? hold_total_ff : '0;
      end
   end

   always_comb begin
      status.hit        = (rd_word_ff.address == addr_ff) && (rd_word_ff.heap == heap_ff);
      status.chk_last   = (chk_ptr_ff + CNT_W'(1)) == count_ff;
      status.rd_live    = rd_live_ff;
      status.rd_freed   = rd_word_ff.freed;
      status.count_zero = count_ff == '0;
      status.count_full = count_ff == CNT_W'(DEPTH);
      status.hold_valid = hold_valid_ff;
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_code  = rsp_code_ff;
   assign rsp_leak_address = rsp_addr_ff;
   assign rsp_leak_size    = rsp_size_ff;
   assign rsp_leaked_total = rsp_total_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

### sv/art_controller.sv
// ----------------------------------------------------------------------------
// Allocation record table controller
// Sequences the table search, the append or update, and the leak report.
// ----------------------------------------------------------------------------
module art_controller
   import art_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_opcode,
   output logic           req_ready,
   input  art_status_type status,
   output art_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_REPLY,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type         state_ff;
   state_type         state_in;
   logic [CODE_W-1:0] reply_code_ff;
   logic [CODE_W-1:0] reply_code_in;
   logic              leak_seen;

   assign leak_seen = status.rd_live && !status.rd_freed;

   always_comb begin
      state_in      = state_ff;
      reply_code_in = reply_code_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               if (req_opcode == OP_RECORD) begin
                  state_in = ST_SEARCH;
               end else if (status.count_zero) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SEARCH: begin
            cmd.advance = 1'b1;
            if (status.rd_live && status.hit) begin
               cmd.wr_hit    = 1'b1;
               reply_code_in = RC_UPDATED;
               state_in      = ST_REPLY;
            end else if ((status.rd_live && status.chk_last) || status.count_zero) begin
               if (status.count_full) begin
                  reply_code_in = RC_FULL;
               end else begin
                  cmd.wr_add    = 1'b1;
                  reply_code_in = RC_ADDED;
               end
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_code = reply_code_ff;
               cmd.rsp_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (leak_seen && status.hold_valid && !status.rsp_free) begin
               cmd.advance = 1'b0;
            end else begin
               cmd.advance = 1'b1;
               if (leak_seen) begin
                  cmd.hold_load = 1'b1;
                  if (status.hold_valid) begin
                     cmd.load_rsp      = 1'b1;
                     cmd.rsp_from_hold = 1'b1;
                     cmd.rsp_code      = RC_LEAK;
                  end
               end
               if (status.rd_live && status.chk_last) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_last = 1'b1;
               if (status.hold_valid) begin
                  cmd.rsp_from_hold = 1'b1;
                  cmd.rsp_code      = RC_LEAK;
               end else begin
                  cmd.rsp_code = RC_NOLEAK;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         reply_code_ff <= RC_UPDATED;
      end else begin
         state_ff      <= state_in;
         reply_code_ff <= reply_code_in;
      end
   end

endmodule

### sim/tb_allocation_record_table_unit.sv
// ----------------------------------------------------------------------------
// Allocation record table unit testbench
// Sends record and report words through the request channel and predicts the
// response words from a shadow copy of the table. Each response word is
// compared field by field with the oldest predicted word. Both channels idle
// at random, with one stretch of full-rate traffic, and the table is filled
// to capacity at the end.
// ----------------------------------------------------------------------------
module tb_allocation_record_table_unit;
   import art_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = ART_DEPTH;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [ADDR_W-1:0] address;
      logic [SIZE_W-1:0] size;
      logic [SIZE_W-1:0] total;
      logic              last;
   } rsp_word_type;

   logic clock;
   logic reset;

   art_req_if req_chan ();
   art_rsp_if rsp_chan ();

   allocation_record_table_unit #(
      .DEPTH (DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [ADDR_W-1:0] shadow_address [DEPTH];
   logic [HEAP_W-1:0] shadow_heap [DEPTH];
   logic [SIZE_W-1:0] shadow_size [DEPTH];
   logic              shadow_freed [DEPTH];
   int                shadow_count = 0;

   rsp_word_type expected_words [$];
   int           error_count = 0;
   int           word_index = 0;
   int           cycle_count = 0;
   bit           no_idle = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_allocation_record_table_unit NOT OK");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (no_idle) begin
         rsp_chan.ready <= 1'b1;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= 25);
      end
   end

   task automatic report_mismatch(input string text);
      if (error_count < 40) begin
         $display("mismatch at response word %0d: %s", word_index, text);
      end
      error_count++;
   endtask

   function automatic rsp_word_type make_word(input logic [CODE_W-1:0] code,
                                              input logic [ADDR_W-1:0] address,
                                              input logic [SIZE_W-1:0] size,
                                              input logic [SIZE_W-1:0] total,
                                              input logic last);
      rsp_word_type w;
      w.code    = code;
      w.address = address;
      w.size    = size;
      w.total   = total;
      w.last    = last;
      return w;
   endfunction

   function automatic void predict_words(input logic op, input logic [ADDR_W-1:0] address,
                                         input logic [HEAP_W-1:0] heap,
                                         input logic [SIZE_W-1:0] size, input logic free);
      int                hit_index;
      int                last_live;
      logic [SIZE_W-1:0] running;
      hit_index = -1;
      last_live = -1;
      running   = '0;
      if (op == OP_RECORD) begin
         for (int i = 0; i < shadow_count; i++) begin
            if (hit_index < 0 && shadow_address[i] == address && shadow_heap[i] == heap) begin
               hit_index = i;
            end
         end
         if (hit_index >= 0) begin
            if (!free) begin
               shadow_size[hit_index] = size;
            end
            shadow_freed[hit_index] = free;
            expected_words.push_back(make_word(RC_UPDATED, '0, '0, '0, 1'b1));
         end else if (shadow_count >= DEPTH) begin
            expected_words.push_back(make_word(RC_FULL, '0, '0, '0, 1'b1));
         end else begin
            shadow_address[shadow_count] = address;
            shadow_heap[shadow_count]    = heap;
            shadow_size[shadow_count]    = size;
            shadow_freed[shadow_count]   = free;
            shadow_count++;
            expected_words.push_back(make_word(RC_ADDED, '0, '0, '0, 1'b1));
         end
      end else begin
         for (int i = 0; i < shadow_count; i++) begin
            if (!shadow_freed[i]) begin
               last_live = i;
            end
         end
         if (last_live < 0) begin
            expected_words.push_back(make_word(RC_NOLEAK, '0, '0, '0, 1'b1));
         end else begin
            for (int i = 0; i <= last_live; i++) begin
               if (!shadow_freed[i]) begin
                  running = running + shadow_size[i];
                  expected_words.push_back(make_word(RC_LEAK, shadow_address[i], shadow_size[i],
                                                     running, i == last_live));
               end
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word with code %0d", rsp_chan.result_code));
         end else begin
            want = expected_words.pop_front();
            if (rsp_chan.result_code !== want.code) begin
               report_mismatch($sformatf("result_code %0d, expected %0d",
                                         rsp_chan.result_code, want.code));
            end
            if (rsp_chan.leak_address !== want.address) begin
               report_mismatch($sformatf("leak_address %h, expected %h",
                                         rsp_chan.leak_address, want.address));
            end
            if (rsp_chan.leak_size !== want.size) begin
               report_mismatch($sformatf("leak_size %h, expected %h",
                                         rsp_chan.leak_size, want.size));
            end
            if (rsp_chan.leaked_total !== want.total) begin
               report_mismatch($sformatf("leaked_total %h, expected %h",
                                         rsp_chan.leaked_total, want.total));
            end
            if (rsp_chan.last !== want.last) begin
               report_mismatch($sformatf("last %b, expected %b", rsp_chan.last, want.last));
            end
         end
         word_index++;
      end
   end

   task automatic send_item(input logic op, input logic [ADDR_W-1:0] address,
                            input logic [HEAP_W-1:0] heap, input logic [SIZE_W-1:0] size,
                            input logic free);
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < 25) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.opcode        <= op;
      req_chan.block_address <= address;
      req_chan.heap_handle   <= heap;
      req_chan.block_size    <= size;
      req_chan.is_free       <= free;
      do begin
         @(posedge clock);
      end while (req_chan.ready !== 1'b1);
      predict_words(op, address, heap, size, free);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_words.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [63:0] rand_wide();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [SIZE_W-1:0] rand_size();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_report();
      send_item(OP_REPORT, rand_wide(), rand_wide(), $urandom, 1'($urandom_range(0, 1)));
   endtask

   task automatic test_empty_report();
      send_item(OP_REPORT, '1, '1, '1, 1'b1);
      send_item(OP_REPORT, '0, '0, '0, 1'b0);
   endtask

   task automatic test_record_update();
      send_item(OP_RECORD, '0, '0, '0, 1'b0);
      send_item(OP_RECORD, '1, '1, '1, 1'b0);
      send_item(OP_RECORD, '1, '0, 32'd1, 1'b0);
      send_item(OP_RECORD, '0, '1, 32'h8000_0000, 1'b1);
      send_item(OP_RECORD, '0, '0, 32'd7, 1'b0);
      send_item(OP_RECORD, '1, '1, 32'd5, 1'b1);
      send_item(OP_RECORD, 64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555, 32'h5A5A_A5A5,
                1'b1);
   endtask

   task automatic test_leak_report();
      send_report();
      send_item(OP_RECORD, '1, '1, '1, 1'b0);
      send_report();
      send_item(OP_RECORD, '0, '0, '0, 1'b0);
      send_report();
   endtask

   task automatic test_all_freed();
      send_item(OP_RECORD, '0, '0, 32'd3, 1'b1);
      send_item(OP_RECORD, '1, '1, '0, 1'b1);
      send_item(OP_RECORD, '1, '0, '1, 1'b1);
      send_report();
      send_item(OP_RECORD, '0, '1, 32'd9, 1'b0);
      send_report();
   endtask

   task automatic test_random_traffic();
      int                pick;
      int                idx;
      logic [ADDR_W-1:0] address;
      logic [HEAP_W-1:0] heap;
      for (int n = 0; n < 230; n++) begin
         no_idle = (n >= 90 && n < 150);
         if (n == 180) begin
            wait_drained();
         end
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            send_report();
         end else if (pick < 32 || shadow_count == 0) begin
            address = rand_wide();
            heap    = rand_wide();
            if (shadow_count > 0) begin
               idx = $urandom_range(0, shadow_count - 1);
               case ($urandom_range(0, 3))
                  0: address = shadow_address[idx];
                  1: heap = shadow_heap[idx];
                  default: ;
               endcase
            end
            send_item(OP_RECORD, address, heap, rand_size(), 1'($urandom_range(0, 1)));
         end else begin
            idx = $urandom_range(0, shadow_count - 1);
            send_item(OP_RECORD, shadow_address[idx], shadow_heap[idx], rand_size(),
                      1'($urandom_range(0, 1)));
         end
      end
      no_idle = 1'b0;
   endtask

   task automatic test_table_full();
      int idx;
      while (shadow_count < DEPTH) begin
         send_item(OP_RECORD, rand_wide(), rand_wide(), rand_size(),
                   1'($urandom_range(0, 1)));
      end
      for (int n = 0; n < 3; n++) begin
         send_item(OP_RECORD, rand_wide(), rand_wide(), rand_size(),
                   1'($urandom_range(0, 1)));
      end
      idx = $urandom_range(0, DEPTH - 1);
      send_item(OP_RECORD, shadow_address[idx], shadow_heap[idx], rand_size(), 1'b0);
      send_report();
      send_item(OP_RECORD, shadow_address[DEPTH - 1], shadow_heap[DEPTH - 1], '1, 1'b0);
      send_report();
   endtask

   initial begin
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.opcode        = OP_RECORD;
      req_chan.block_address = '0;
      req_chan.heap_handle   = '0;
      req_chan.block_size    = '0;
      req_chan.is_free       = 1'b0;
      rsp_chan.ready         = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_report();
      test_record_update();
      test_leak_report();
      test_all_freed();
      test_random_traffic();
      test_table_full();

      wait_drained();
      repeat (2 * DEPTH + 16) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_allocation_record_table_unit OK");
      end else begin
         $display("tb_allocation_record_table_unit NOT OK");
      end
      $finish;
   end

endmodule
